FILE: rtl/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types and codes for the timed priority task table.
// ----------------------------------------------------------------------------
package tpt_pkg;

    localparam logic [2:0] MODE_ENQUEUE = 3'd0;
    localparam logic [2:0] MODE_DEQUEUE = 3'd1;
    localparam logic [2:0] MODE_CANCEL  = 3'd2;
    localparam logic [2:0] MODE_LOOKUP  = 3'd3;
    localparam logic [2:0] MODE_UPDATE  = 3'd4;
    localparam logic [2:0] MODE_COUNT   = 3'd5;

    localparam logic [2:0] ST_PENDING   = 3'd0;
    localparam logic [2:0] ST_CANCELLED = 3'd1;

    // one stored task record
    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  prio;
        logic [47:0] deadline;
        logic [47:0] release_time;
        logic [2:0]  state;
        logic [15:0] progress;
    } rec_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] task_id;
        logic [7:0]  task_priority;
        logic [47:0] task_deadline;
        logic [47:0] task_release_time;
        logic [2:0]  state_code;
        logic [15:0] progress_value;
        logic        keep_progress;
        logic [47:0] now_time;
    } cmd_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] out_task_id;
        logic [7:0]  out_priority;
        logic [47:0] out_deadline;
        logic [47:0] out_release_time;
        logic [2:0]  out_state;
        logic [15:0] out_progress;
        logic [4:0]  entry_count;
        logic [4:0]  pending_count;
        logic        table_full;
    } rsp_t;

endpackage

FILE: rtl/tpt_ifs.sv
// ----------------------------------------------------------------------------
// tpt_ifs
// Valid/ready channels of the task table: command, result, configuration.
// ----------------------------------------------------------------------------
interface tpt_cmd_if import tpt_pkg::*; ();
    logic valid;
    logic ready;
    cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tpt_rsp_if import tpt_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tpt_cfg_if ();
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/timed_priority_task_table.sv
// ----------------------------------------------------------------------------
// timed_priority_task_table
// Ordered task table with id lookup, FIFO or priority dequeue and compaction.
// ----------------------------------------------------------------------------
// Each command takes one beat on cmd and gives one beat on rsp. Records live
// in a single-port-write, single-port-read memory with registered read
// data; every command scans the occupied slots in order, one read issued
// per cycle, then acts and registers the result beat (the scan is skipped
// on an empty table), waiting while an earlier result is still unaccepted,
// and then returns to idle to take the next command. A dequeue that leaves
// records behind the removed one compacts the table, moving each of them
// down one slot through a read state and a write state. One command is in
// flight at a time; the result sits in an output register, so cmd is ready
// again while the previous result waits. priority_mode is written on cfg
// (always ready) and is sampled during the dequeue scan.
module timed_priority_task_table
    import tpt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    tpt_cmd_if.sink   cmd,
    tpt_rsp_if.source rsp,
    tpt_cfg_if.sink   cfg
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_ACT  = 3'd2;
    localparam logic [2:0] S_SHRD = 3'd3;
    localparam logic [2:0] S_SHWR = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]    state_reg,  state_next;
    cmd_t          cmd_reg,    cmd_next;
    logic          pm_reg;
    logic [CW-1:0] occ_reg,    occ_next;
    logic [CW-1:0] pend_reg,   pend_next;
    logic [CW-1:0] issue_reg,  issue_next;
    logic          rvalid_reg, rvalid_next;
    logic [CW-1:0] ridx_reg,   ridx_next;
    logic          found_reg,  found_next;
    logic [IW-1:0] fidx_reg,   fidx_next;
    rec_t          rec_reg,    rec_next;
    logic          ok_reg,     ok_next;
    logic          full_reg,   full_next;
    logic [IW-1:0] ptr_reg,    ptr_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_data_reg,  rsp_data_next;

    // memory port
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    rec_t          mem_wdata;
    logic [IW-1:0] mem_raddr;
    rec_t          mem_rdata;

    logic          take;
    rec_t          new_rec;
    logic          new_pend;
    logic          old_pend;

    tpt_store #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tpt_pick u_pick (
        .cand       (mem_rdata),
        .best       (rec_reg),
        .have_best  (found_reg),
        .is_dequeue (cmd_reg.mode == MODE_DEQUEUE),
        .prio_mode  (pm_reg),
        .key_id     (cmd_reg.task_id),
        .now_time   (cmd_reg.now_time),
        .take       (take)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // record built from the command for enqueue
    always_comb
    begin
        new_rec.id           = cmd_reg.task_id;
        new_rec.prio         = cmd_reg.task_priority;
        new_rec.deadline     = cmd_reg.task_deadline;
        new_rec.release_time = cmd_reg.task_release_time;
        new_rec.state        = cmd_reg.state_code;
        new_rec.progress     = cmd_reg.progress_value;
        new_pend             = (cmd_reg.state_code == ST_PENDING);
        old_pend             = (rec_reg.state == ST_PENDING);
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        occ_next       = occ_reg;
        pend_next      = pend_reg;
        issue_next     = issue_reg;
        rvalid_next    = 1'b0;
        ridx_next      = ridx_reg;
        found_next     = found_reg;
        fidx_next      = fidx_reg;
        rec_next       = rec_reg;
        ok_next        = ok_reg;
        full_next      = full_reg;
        ptr_next       = ptr_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = fidx_reg;
        mem_wdata      = rec_reg;
        mem_raddr      = issue_reg[IW-1:0];

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next   = cmd.data;
                    issue_next = '0;
                    found_next = 1'b0;
                    ok_next    = 1'b0;
                    full_next  = 1'b0;
                    state_next = (occ_reg == '0) ? S_ACT : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // issue next read
                if (issue_reg < occ_reg)
                begin
                    rvalid_next = 1'b1;
                    ridx_next   = issue_reg;
                    issue_next  = issue_reg + CW'(1);
                end
                // consume returned record
                if (rvalid_reg)
                begin
                    if (take)
                    begin
                        found_next = 1'b1;
                        fidx_next  = ridx_reg[IW-1:0];
                        rec_next   = mem_rdata;
                    end
                    if ((ridx_reg + CW'(1)) == occ_reg)
                    begin
                        state_next = S_ACT;
                    end
                end
            end

            S_ACT:
            begin
                state_next = S_FIN;
                case (cmd_reg.mode)
                    MODE_ENQUEUE:
                    begin
                        if (found_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = fidx_reg;
                            mem_wdata = new_rec;
                            ok_next   = 1'b1;
                            pend_next = pend_reg - CW'(old_pend) + CW'(new_pend);
                        end
                        else if (occ_reg >= CW'(CAPACITY))
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = occ_reg[IW-1:0];
                            mem_wdata = new_rec;
                            ok_next   = 1'b1;
                            occ_next  = occ_reg + CW'(1);
                            pend_next = pend_reg + CW'(new_pend);
                        end
                    end
                    MODE_DEQUEUE:
                    begin
                        if (found_reg)
                        begin
                            ok_next   = 1'b1;
                            occ_next  = occ_reg - CW'(1);
                            pend_next = pend_reg - CW'(1);
                            ptr_next  = fidx_reg;
                            // close the gap if records follow
                            if (CW'(fidx_reg) < (occ_reg - CW'(1)))
                            begin
                                state_next = S_SHRD;
                            end
                        end
                    end
                    MODE_CANCEL:
                    begin
                        if (found_reg)
                        begin
                            mem_we          = 1'b1;
                            mem_wdata       = rec_reg;
                            mem_wdata.state = ST_CANCELLED;
                            ok_next         = 1'b1;
                            pend_next       = pend_reg - CW'(old_pend);
                        end
                    end
                    MODE_LOOKUP:
                    begin
                        ok_next = found_reg;
                    end
                    MODE_UPDATE:
                    begin
                        if (found_reg)
                        begin
                            mem_we          = 1'b1;
                            mem_wdata       = rec_reg;
                            mem_wdata.state = cmd_reg.state_code;
                            if (!cmd_reg.keep_progress)
                            begin
                                mem_wdata.progress = cmd_reg.progress_value;
                            end
                            ok_next   = 1'b1;
                            pend_next = pend_reg - CW'(old_pend) + CW'(new_pend);
                        end
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end

            S_SHRD:
            begin
                mem_raddr  = IW'(ptr_reg + 1'b1);
                state_next = S_SHWR;
            end

            S_SHWR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                ptr_next  = IW'(ptr_reg + 1'b1);
                // occ_reg already holds the reduced count
                if ((CW'(ptr_reg) + CW'(1)) < occ_reg)
                begin
                    state_next = S_SHRD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = '0;
                    rsp_data_next.ok = ok_reg;
                    if (ok_reg && ((cmd_reg.mode == MODE_DEQUEUE) ||
                                   (cmd_reg.mode == MODE_LOOKUP)))
                    begin
                        rsp_data_next.out_task_id      = rec_reg.id;
                        rsp_data_next.out_priority     = rec_reg.prio;
                        rsp_data_next.out_deadline     = rec_reg.deadline;
                        rsp_data_next.out_release_time = rec_reg.release_time;
                        rsp_data_next.out_state        = rec_reg.state;
                        rsp_data_next.out_progress     = rec_reg.progress;
                    end
                    rsp_data_next.entry_count   = 5'(occ_reg);
                    rsp_data_next.pending_count = 5'(pend_reg);
                    rsp_data_next.table_full    = full_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pm_reg        <= 1'b0;
            occ_reg       <= '0;
            pend_reg      <= '0;
            rvalid_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            pend_reg      <= pend_next;
            rvalid_reg    <= rvalid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid)
            begin
                pm_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        issue_reg    <= issue_next;
        ridx_reg     <= ridx_next;
        found_reg    <= found_next;
        fidx_reg     <= fidx_next;
        rec_reg      <= rec_next;
        ok_reg       <= ok_next;
        full_reg     <= full_next;
        ptr_reg      <= ptr_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule

FILE: rtl/tpt_store.sv
// ----------------------------------------------------------------------------
// tpt_store
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tpt_store
    import tpt_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int IW       = 4
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  rec_t          wdata,
    input  logic [IW-1:0] raddr,
    output rec_t          rdata
);

    rec_t mem [CAPACITY];
    rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tpt_pick.sv
// ----------------------------------------------------------------------------
// tpt_pick
// Scan decision: does the record just read replace the current candidate.
// ----------------------------------------------------------------------------
module tpt_pick
    import tpt_pkg::*;
(
    input  rec_t        cand,
    input  rec_t        best,
    input  logic        have_best,
    input  logic        is_dequeue,
    input  logic        prio_mode,
    input  logic [31:0] key_id,
    input  logic [47:0] now_time,
    output logic        take
);

    logic eligible;
    logic better;

    always_comb
    begin
        eligible = (cand.release_time <= now_time) && (cand.state == ST_PENDING);
        better   = (cand.prio > best.prio) ||
                   ((cand.prio == best.prio) && (cand.deadline < best.deadline));
        if (is_dequeue)
        begin
            take = eligible && (!have_best || (prio_mode && better));
        end
        else
        begin
            // first match wins: later duplicates are ignored
            take = !have_best && (cand.id == key_id);
        end
    end

endmodule

FILE: rtl/tpt_checker.sv
// ----------------------------------------------------------------------------
// tpt_checker
// Port-level checks of the task table results, bound to the top level.
// ----------------------------------------------------------------------------
module tpt_checker
#(
    parameter int CAPACITY = 16
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        ok,
    input logic        table_full,
    input logic [31:0] out_task_id,
    input logic [15:0] out_progress,
    input logic [4:0]  entry_count,
    input logic [4:0]  pending_count
);

    localparam bit SMALL_TABLE = (CAPACITY <= 31);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && SMALL_TABLE) |-> (32'(entry_count) <= CAPACITY))
        else $error("entry_count above capacity");

    a_pend_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && SMALL_TABLE) |-> (pending_count <= entry_count))
        else $error("pending_count above entry_count");

    a_full_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && table_full) |-> !ok)
        else $error("table_full with ok");

    a_empty_record: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !ok) |-> ((out_task_id == '0) && (out_progress == '0)))
        else $error("record fields set without ok");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(entry_count)))
        else $error("result dropped while stalled");

endmodule

bind timed_priority_task_table tpt_checker #(
    .CAPACITY (CAPACITY)
) u_tpt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .ok            (rsp.data.ok),
    .table_full    (rsp.data.table_full),
    .out_task_id   (rsp.data.out_task_id),
    .out_progress  (rsp.data.out_progress),
    .entry_count   (rsp.data.entry_count),
    .pending_count (rsp.data.pending_count)
);

FILE: tb/sv/tpt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_tb_checker
// Watches the command, result and config channels of the task table, keeps
// its own copy of the table and compares every result beat against it.
// ----------------------------------------------------------------------------
module tpt_tb_checker
    import tpt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    tpt_cmd_if        cmd,
    tpt_rsp_if        rsp,
    tpt_cfg_if        cfg,
    output int        fail_count,
    output int        pending_results
);

    rec_t table_q[$];
    logic prio_mode;
    rsp_t expected_rsp_q[$];

    function automatic int find_task(logic [31:0] id);
        for (int i = 0; i < table_q.size(); i++)
            if (table_q[i].id == id)
                return i;
        return -1;
    endfunction

    function automatic rsp_t predict_rsp(cmd_t c);
        rsp_t r;
        int f;
        int best;
        int pend;
        rec_t nr;
        r = '0;
        f = find_task(c.task_id);
        case (c.mode)
            MODE_ENQUEUE:
            begin
                nr.id = c.task_id;
                nr.prio = c.task_priority;
                nr.deadline = c.task_deadline;
                nr.release_time = c.task_release_time;
                nr.state = c.state_code;
                nr.progress = c.progress_value;
                if (f >= 0)
                begin
                    table_q[f] = nr;
                    r.ok = 1'b1;
                end
                else if (table_q.size() >= CAPACITY)
                    r.table_full = 1'b1;
                else
                begin
                    table_q.insert(table_q.size(), nr);
                    r.ok = 1'b1;
                end
            end
            MODE_DEQUEUE:
            begin
                best = -1;
                for (int i = 0; i < table_q.size(); i++)
                begin
                    if (table_q[i].release_time > c.now_time ||
                        table_q[i].state != ST_PENDING)
                        continue;
                    if (best < 0)
                        best = i;
                    else if (prio_mode &&
                             (table_q[i].prio > table_q[best].prio ||
                              (table_q[i].prio == table_q[best].prio &&
                               table_q[i].deadline < table_q[best].deadline)))
                        best = i;
                end
                if (best >= 0)
                begin
                    {r.out_task_id, r.out_priority, r.out_deadline,
                     r.out_release_time, r.out_state, r.out_progress} = table_q[best];
                    r.ok = 1'b1;
                    table_q.delete(best);
                end
            end
            MODE_CANCEL:
                if (f >= 0)
                begin
                    table_q[f].state = ST_CANCELLED;
                    r.ok = 1'b1;
                end
            MODE_LOOKUP:
                if (f >= 0)
                begin
                    {r.out_task_id, r.out_priority, r.out_deadline,
                     r.out_release_time, r.out_state, r.out_progress} = table_q[f];
                    r.ok = 1'b1;
                end
            MODE_UPDATE:
                if (f >= 0)
                begin
                    table_q[f].state = c.state_code;
                    if (!c.keep_progress)
                        table_q[f].progress = c.progress_value;
                    r.ok = 1'b1;
                end
            default: ;
        endcase
        pend = 0;
        foreach (table_q[i])
            if (table_q[i].state == ST_PENDING)
                pend++;
        r.entry_count = 5'(table_q.size());
        r.pending_count = 5'(pend);
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t e;
        rsp_t a;
        if (!rst_n)
        begin
            table_q.delete();
            expected_rsp_q.delete();
            prio_mode = 1'b0;
            fail_count = 0;
            pending_results = 0;
        end
        else
        begin
            // result first: its expectation was queued on an earlier beat
            if (rsp.valid && rsp.ready)
            begin
                a = rsp.data;
                if (expected_rsp_q.size() == 0)
                begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    e = expected_rsp_q.pop_front();
                    check_field("ok", e.ok, a.ok);
                    check_field("out_task_id", e.out_task_id, a.out_task_id);
                    check_field("out_priority", e.out_priority, a.out_priority);
                    check_field("out_deadline", e.out_deadline, a.out_deadline);
                    check_field("out_release_time", e.out_release_time,
                                a.out_release_time);
                    check_field("out_state", e.out_state, a.out_state);
                    check_field("out_progress", e.out_progress, a.out_progress);
                    check_field("entry_count", e.entry_count, a.entry_count);
                    check_field("pending_count", e.pending_count, a.pending_count);
                    check_field("table_full", e.table_full, a.table_full);
                end
            end
            if (cfg.valid && cfg.ready)
                prio_mode = cfg.data;
            if (cmd.valid && cmd.ready)
                expected_rsp_q.insert(expected_rsp_q.size(), predict_rsp(cmd.data));
            pending_results = expected_rsp_q.size();
        end
    end

endmodule

FILE: tb/sv/timed_priority_task_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_priority_task_table_tb
// Drives directed and random table commands with random gaps and result
// stalls under both dequeue modes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module timed_priority_task_table_tb;
    import tpt_pkg::*;

    localparam int CAPACITY = 16;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_results;
    bit   stall_long;      // set by stimulus, asks the result side for a long hold-off
    bit   stall_done;

    tpt_cmd_if cmd ();
    tpt_rsp_if rsp ();
    tpt_cfg_if cfg ();

    timed_priority_task_table #(.CAPACITY(CAPACITY)) uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    tpt_tb_checker #(.CAPACITY(CAPACITY)) u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .rsp             (rsp),
        .cfg             (cfg),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Small id pool so replace, cancel, lookup and update often hit.
    logic [31:0] id_pool [8];

    // Gap length: mostly zero or short, sometimes long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: random stalls, plus one long hold-off on request so the
    // block's output register fills and cmd backs up.
    initial
    begin
        int n;
        rsp.ready <= 1'b0;
        stall_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_long && !stall_done)
            begin
                rsp.ready <= 1'b0;
                repeat (400) @(posedge clk);
                stall_done = 1'b1;
            end
            n = gap_len();
            if (n == 0 || $urandom_range(0, 3) == 0)
                rsp.ready <= 1'b1;
            else
            begin
                rsp.ready <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end
        end
    end

    task automatic send_beat(cmd_t c);
        int n;
        n = gap_len();
        if (n > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.data  <= c;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
    endtask

    task automatic write_mode(logic m);
        cmd.valid <= 1'b0;
        // let the checker count the beat taken on this edge
        @(posedge clk);
        // drain: every expected result back, then a margin for the scan
        while (pending_results != 0)
            @(posedge clk);
        repeat (3 * CAPACITY + 10) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= m;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic cmd_t rand_cmd(logic [47:0] base_time);
        cmd_t c;
        int r;
        c.task_id           = ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, 7)];
        c.task_priority     = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        c.task_deadline     = ($urandom_range(0, 3) == 0) ? rand48()
                                                          : base_time + $urandom_range(0, 50);
        c.task_release_time = ($urandom_range(0, 5) == 0) ? rand48()
                                                          : base_time + $urandom_range(0, 40);
        c.state_code        = ($urandom_range(0, 2) == 0) ? 3'($urandom) : ST_PENDING;
        c.progress_value    = 16'($urandom);
        c.keep_progress     = 1'($urandom);
        c.now_time          = ($urandom_range(0, 9) == 0) ? rand48()
                                                          : base_time + $urandom_range(0, 60);
        r = $urandom_range(0, 99);
        if (r < 38)      c.mode = MODE_ENQUEUE;
        else if (r < 70) c.mode = MODE_DEQUEUE;
        else if (r < 77) c.mode = MODE_CANCEL;
        else if (r < 85) c.mode = MODE_LOOKUP;
        else if (r < 93) c.mode = MODE_UPDATE;
        else if (r < 97) c.mode = MODE_COUNT;
        else             c.mode = 3'($urandom_range(6, 7));
        return c;
    endfunction

    initial
    begin
        cmd_t c;
        logic [47:0] base_time;
        cmd.valid <= 1'b0;
        cmd.data  <= '0;
        cfg.valid <= 1'b0;
        cfg.data  <= 1'b0;
        stall_long = 1'b0;
        rst_n = 1'b0;
        foreach (id_pool[i])
            id_pool[i] = $urandom;
        id_pool[0] = 32'h0;
        id_pool[1] = 32'hFFFF_FFFF;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: empty-table dequeue, extremes, full table, ties ----
        write_mode(1'b1);
        c = '0;
        c.mode = MODE_DEQUEUE;                 // empty table
        send_beat(c);
        c.mode = MODE_LOOKUP;                  // miss
        send_beat(c);
        // fill to capacity; equal priorities with spread deadlines for tie-break
        for (int i = 0; i < CAPACITY; i++)
        begin
            c = '0;
            c.mode = MODE_ENQUEUE;
            c.task_id = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : 32'(100 + i);
            c.task_priority = (i < 4) ? 8'hFF : 8'(i);
            c.task_deadline = (i == 2) ? 48'h0 : (i == 3) ? '1 : 48'(1000 - i);
            c.task_release_time = (i == 5) ? '1 : 48'(i);
            c.state_code = (i == 6) ? 3'd7 : ST_PENDING;
            c.progress_value = (i == 7) ? 16'hFFFF : 16'(i);
            send_beat(c);
        end
        c.task_id = 32'h5555_AAAA;             // new id into a full table
        send_beat(c);
        c.task_id = 32'hFFFF_FFFF;             // replace while full
        c.task_priority = 8'h0;
        send_beat(c);
        c = '0;
        c.mode = MODE_UPDATE;                  // keep progress
        c.task_id = 32'(107);
        c.state_code = 3'd3;
        c.keep_progress = 1'b1;
        c.progress_value = 16'h1234;
        send_beat(c);
        c.keep_progress = 1'b0;                // overwrite progress
        c.state_code = ST_PENDING;
        send_beat(c);
        c.mode = MODE_CANCEL;
        c.task_id = 32'h0;
        send_beat(c);
        c.mode = MODE_LOOKUP;
        send_beat(c);
        c = '0;
        c.mode = MODE_DEQUEUE;                 // now zero: only release time 0, and that task is cancelled
        send_beat(c);
        c.now_time = '1;                       // everything released
        send_beat(c);
        send_beat(c);
        c.mode = MODE_COUNT;
        send_beat(c);
        c.mode = 3'd7;
        send_beat(c);

        // ---- random phases, alternating dequeue mode ----
        base_time = 48'd1000;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_mode(ph[0]);
            for (int k = 0; k < 220; k++)
            begin
                if (ph == 2 && k == 20)
                    stall_long = 1'b1;
                if ($urandom_range(0, 7) == 0)
                    base_time = base_time + $urandom_range(0, 30);
                send_beat(rand_cmd(base_time));
            end
        end
        cmd.valid <= 1'b0;

        fork
        begin
            @(posedge clk);
            while (pending_results != 0)
                @(posedge clk);
            repeat (3 * CAPACITY + 10) @(posedge clk);
        end
        join
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
